// ===== design/tlbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbm_pkg
// Shared types and codes for the push-button traffic light controller.
// ----------------------------------------------------------------------------
package tlbm_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned CfgIdxW = 3;

  // Light codes as kept in the history registers and the pending phase.
  localparam logic [1:0] LIGHT_NONE   = 2'd0;
  localparam logic [1:0] LIGHT_GREEN  = 2'd1;
  localparam logic [1:0] LIGHT_YELLOW = 2'd2;
  localparam logic [1:0] LIGHT_RED    = 2'd3;

  // Bit positions in the lamp vector.
  localparam int unsigned LAMP_G = 0;
  localparam int unsigned LAMP_Y = 1;
  localparam int unsigned LAMP_R = 2;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_BLINK  = 2'd1;
  localparam logic [1:0] MODE_OFF    = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_GREEN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_YELLOW = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RED    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MEDIUM = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LONG   = 3'd4;

  localparam logic [TickW-1:0] RST_GREEN_TICKS  = 16'd40;
  localparam logic [TickW-1:0] RST_YELLOW_TICKS = 16'd8;
  localparam logic [TickW-1:0] RST_RED_TICKS    = 16'd20;
  localparam logic [TickW-1:0] RST_MEDIUM_TICKS = 16'd6;
  localparam logic [TickW-1:0] RST_LONG_TICKS   = 16'd20;

  typedef struct packed {
    logic [TickW-1:0] green_ticks;
    logic [TickW-1:0] yellow_ticks;
    logic [TickW-1:0] red_ticks;
    logic [TickW-1:0] medium_press_ticks;
    logic [TickW-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       lamps;
    logic [TickW-1:0] phase_timer;
    logic [1:0]       pending_lamp;
    logic             blink_mode;
    logic             blink_running;
    logic             halted;
    logic [1:0]       last_light;
    logic [1:0]       light_at_press;
    logic [1:0]       last_seen_light;
    logic [TickW-1:0] press_ticks;
    logic             button_prev;
    logic             blue_on;
  } state_t;

  typedef struct packed {
    logic       green_lamp;
    logic       yellow_lamp;
    logic       red_lamp;
    logic       press_lamp;
    logic [1:0] mode;
  } result_t;

endpackage

// ===== design/traffic_light_button_modes_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traffic_light_button_modes_core
// Push-button traffic light controller, one request per half-second tick.
// ----------------------------------------------------------------------------
// Each accepted request is one tick carrying the button level; the block
// updates its light state in the cycle of acceptance and delivers one result
// (lamps, blue press lamp, mode) through a registered result queue. It takes
// one request per clock while the queue has room, the next-state logic being
// combinational; a two-entry result queue lets it keep accepting while one
// result waits, and it stalls input only when both entries are full. Config
// writes are always ready and should be made while the block is idle.
module traffic_light_button_modes_core import tlbm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_button_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_green_lamp,
  output logic               out_yellow_lamp,
  output logic               out_red_lamp,
  output logic               out_press_lamp,
  output logic [1:0]         out_mode,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TickW-1:0]   cfg_data
);

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t q_r [2];
  logic [1:0] cnt_r;
  logic push;
  logic pop;
  logic wr_sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.green_ticks        <= RST_GREEN_TICKS;
      cfg_r.yellow_ticks       <= RST_YELLOW_TICKS;
      cfg_r.red_ticks          <= RST_RED_TICKS;
      cfg_r.medium_press_ticks <= RST_MEDIUM_TICKS;
      cfg_r.long_press_ticks   <= RST_LONG_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GREEN:  cfg_r.green_ticks        <= cfg_data;
        CFG_YELLOW: cfg_r.yellow_ticks       <= cfg_data;
        CFG_RED:    cfg_r.red_ticks          <= cfg_data;
        CFG_MEDIUM: cfg_r.medium_press_ticks <= cfg_data;
        CFG_LONG:   cfg_r.long_press_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  tlbm_step u_step (
    .cur          (state_r),
    .cfg          (cfg_r),
    .button_level (in_button_level),
    .nxt          (state_nxt),
    .res          (res_nxt)
  );

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign pop      = out_valid && !out_stall;
  // A pop frees the head, so the new result lands one place lower.
  assign wr_sel   = cnt_r[0] & ~pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.lamps           <= 3'b001;
      state_r.phase_timer     <= RST_GREEN_TICKS;
      state_r.pending_lamp    <= LIGHT_YELLOW;
      state_r.blink_mode      <= 1'b0;
      state_r.blink_running   <= 1'b0;
      state_r.halted          <= 1'b0;
      state_r.last_light      <= LIGHT_GREEN;
      state_r.light_at_press  <= LIGHT_GREEN;
      state_r.last_seen_light <= LIGHT_GREEN;
      state_r.press_ticks     <= '0;
      state_r.button_prev     <= 1'b0;
      state_r.blue_on         <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) state_r <= state_nxt;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && !wr_sel) q_r[0] <= res_nxt;
    else if (pop) q_r[0] <= q_r[1];
    if (push && wr_sel) q_r[1] <= res_nxt;
  end

  assign out_green_lamp  = q_r[0].green_lamp;
  assign out_yellow_lamp = q_r[0].yellow_lamp;
  assign out_red_lamp    = q_r[0].red_lamp;
  assign out_press_lamp  = q_r[0].press_lamp;
  assign out_mode        = q_r[0].mode;

  a_lamps_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(state_r.lamps))
    else $error("more than one traffic lamp lit");

  a_blink_locks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.blink_running |-> (state_r.blink_mode && !state_r.halted))
    else $error("blink toggle running outside blink mode or in shutdown");

  a_queue_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("result queue count did not drop on a pop");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue overflow");

endmodule

// ===== design/tlbm_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbm_step
// Next-state logic for one half-second tick: phase timer, blink toggle and
// button handling, plus the lamp and mode outputs seen after the update.
// ----------------------------------------------------------------------------
module tlbm_step import tlbm_pkg::*; (
  input  state_t  cur,
  input  cfg_t    cfg,
  input  logic    button_level,
  output state_t  nxt,
  output result_t res
);

  function automatic logic lamp_allowed(state_t s, logic [1:0] k);
    logic ok;
    begin
      unique case (k)
        LIGHT_GREEN, LIGHT_RED: ok = !s.blink_mode && !s.halted;
        LIGHT_YELLOW: ok = (!s.blink_mode || (s.light_at_press == LIGHT_GREEN)) &&
                           !s.halted;
        default: ok = 1'b0;
      endcase
      return ok;
    end
  endfunction

  // Starts lamp k if its lock allows it, otherwise leaves the state alone.
  function automatic state_t start_lamp(state_t s, cfg_t c, logic [1:0] k);
    state_t t;
    begin
      t = s;
      if (lamp_allowed(s, k)) begin
        unique case (k)
          LIGHT_GREEN: begin
            t.lamps = 3'b001;
            t.pending_lamp = LIGHT_YELLOW;
            t.phase_timer = c.green_ticks;
          end
          LIGHT_YELLOW: begin
            t.lamps = 3'b010;
            t.pending_lamp = LIGHT_RED;
            t.phase_timer = c.yellow_ticks;
          end
          LIGHT_RED: begin
            t.lamps = 3'b100;
            t.pending_lamp = LIGHT_GREEN;
            t.phase_timer = c.red_ticks;
          end
          default: t = s;
        endcase
      end
      return t;
    end
  endfunction

  function automatic state_t start_blinking(state_t s);
    state_t t;
    begin
      t = s;
      t.lamps = 3'b000;
      t.blink_mode = 1'b1;
      t.blink_running = 1'b1;
      return t;
    end
  endfunction

  always_comb begin
    state_t     s;
    logic [1:0] seen;
    logic       is_medium;
    logic       is_long;

    s = cur;

    // Phase timer.
    if (s.pending_lamp != LIGHT_NONE) begin
      if (s.phase_timer <= 16'd1) begin
        s.phase_timer = '0;
        if (lamp_allowed(s, s.pending_lamp)) begin
          s = start_lamp(s, cfg, s.pending_lamp);
        end else begin
          s.pending_lamp = LIGHT_NONE;
        end
      end else begin
        s.phase_timer = s.phase_timer - 16'd1;
      end
    end

    if (s.blink_running) begin
      s.lamps[LAMP_Y] = ~s.lamps[LAMP_Y];
      s.blink_mode = 1'b1;
    end

    // The lamp seen is the first lit one, or the previous one when all are dark.
    priority if (s.lamps[LAMP_G]) seen = LIGHT_GREEN;
    else if (s.lamps[LAMP_Y]) seen = LIGHT_YELLOW;
    else if (s.lamps[LAMP_R]) seen = LIGHT_RED;
    else seen = s.last_seen_light;

    is_medium = (s.press_ticks >= cfg.medium_press_ticks) &&
                (s.press_ticks < cfg.long_press_ticks);
    is_long   = s.press_ticks >= cfg.long_press_ticks;

    if (button_level && !s.button_prev) begin
      s.last_seen_light = seen;
      s.light_at_press = seen;
      if (!s.blink_mode) s.last_light = seen;
      s.press_ticks = 16'd1;
      s.blue_on = 1'b1;
    end else if (button_level) begin
      if (s.press_ticks != 16'hFFFF) s.press_ticks = s.press_ticks + 16'd1;
      s.blue_on = ~s.blue_on;
    end else if (s.button_prev) begin
      s.blue_on = 1'b0;
      if (is_medium && !s.halted) begin
        if (!s.blink_mode) begin
          s = start_blinking(s);
        end else begin
          s.blink_running = 1'b0;
          s.blink_mode = 1'b0;
          s = start_lamp(s, cfg, s.last_light);
        end
      end else if (is_long) begin
        if (!s.halted) begin
          s.blink_running = 1'b0;
          s.halted = 1'b1;
          s.lamps = 3'b000;
        end else if (!s.blink_mode) begin
          s.halted = 1'b0;
          s = start_lamp(s, cfg, s.light_at_press);
        end else begin
          s.halted = 1'b0;
          s = start_blinking(s);
        end
      end else if ((s.last_light == LIGHT_GREEN) &&
                   (s.press_ticks < cfg.medium_press_ticks) && !s.blink_mode) begin
        s = start_lamp(s, cfg, LIGHT_YELLOW);
      end else begin
        s = start_lamp(s, cfg, s.light_at_press);
      end
    end
    s.button_prev = button_level;

    nxt = s;
    res.green_lamp  = s.lamps[LAMP_G];
    res.yellow_lamp = s.lamps[LAMP_Y];
    res.red_lamp    = s.lamps[LAMP_R];
    res.press_lamp  = s.blue_on;
    if (s.halted) res.mode = MODE_OFF;
    else if (s.blink_mode) res.mode = MODE_BLINK;
    else res.mode = MODE_NORMAL;
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the push-button traffic light controller.
// ----------------------------------------------------------------------------
// Tick requests come from a queue that the stimulus process fills in phases.
// Each phase writes the five timing registers while the block is idle, then
// sends button press and release sequences, with some random noise mixed in.
// A predictor mirrors the light state per accepted tick. The monitor checks
// every delivered result, field by field, against the oldest prediction.
module tb;
  import tlbm_pkg::*;

  localparam int unsigned HoldCycles = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_button_level = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_green_lamp;
  logic               out_yellow_lamp;
  logic               out_red_lamp;
  logic               out_press_lamp;
  logic [1:0]         out_mode;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [TickW-1:0]   cfg_data = '0;

  traffic_light_button_modes_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_button_level (in_button_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_green_lamp  (out_green_lamp),
    .out_yellow_lamp (out_yellow_lamp),
    .out_red_lamp    (out_red_lamp),
    .out_press_lamp  (out_press_lamp),
    .out_mode        (out_mode),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the timing registers and the light state.
  cfg_t             timing;
  logic [2:0]       lit;
  logic [TickW-1:0] phase_left;
  logic [1:0]       next_light;
  logic             blink_on;
  logic             blink_tick;
  logic             is_off;
  logic [1:0]       resume_light;
  logic [1:0]       press_light;
  logic [1:0]       shown_light;
  logic [TickW-1:0] held_ticks;
  logic             btn_q;
  logic             blue_q;

  logic    tick_queue[$];
  result_t lamp_expect[$];
  int      ticks_queued = 0;
  int      ticks_taken = 0;
  int      mismatches = 0;
  int      idle_mode = 0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;
  logic    offer_taken = 1'b0;

  function automatic bit light_start(logic [1:0] which);
    case (which)
      LIGHT_GREEN: begin
        if (blink_on || is_off) return 1'b0;
        lit = '0;
        lit[LAMP_G] = 1'b1;
        next_light = LIGHT_YELLOW;
        phase_left = timing.green_ticks;
        return 1'b1;
      end
      LIGHT_YELLOW: begin
        // Yellow may start during blinking only if the press saw green.
        if (!((!blink_on || press_light == LIGHT_GREEN) && !is_off)) return 1'b0;
        lit = '0;
        lit[LAMP_Y] = 1'b1;
        next_light = LIGHT_RED;
        phase_left = timing.yellow_ticks;
        return 1'b1;
      end
      LIGHT_RED: begin
        if (blink_on || is_off) return 1'b0;
        lit = '0;
        lit[LAMP_R] = 1'b1;
        next_light = LIGHT_GREEN;
        phase_left = timing.red_ticks;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void enter_blink();
    lit = '0;
    blink_on = 1'b1;
    blink_tick = 1'b1;
  endfunction

  function automatic result_t advance_tick(logic level);
    logic [1:0] pending;
    logic       mid_press;
    logic       long_press;
    result_t    res;
    if (next_light != LIGHT_NONE) begin
      if (phase_left <= 1) begin
        pending = next_light;
        phase_left = '0;
        if (!light_start(pending)) next_light = LIGHT_NONE;
      end else begin
        phase_left = phase_left - 1'b1;
      end
    end
    if (blink_tick) begin
      lit[LAMP_Y] = ~lit[LAMP_Y];
      blink_on = 1'b1;
    end
    if (level && !btn_q) begin
      if (lit[LAMP_G]) shown_light = LIGHT_GREEN;
      else if (lit[LAMP_Y]) shown_light = LIGHT_YELLOW;
      else if (lit[LAMP_R]) shown_light = LIGHT_RED;
      press_light = shown_light;
      if (!blink_on) resume_light = shown_light;
      held_ticks = 16'd1;
      blue_q = 1'b1;
    end else if (level) begin
      if (held_ticks != 16'hFFFF) held_ticks = held_ticks + 1'b1;
      blue_q = ~blue_q;
    end else if (btn_q) begin
      blue_q = 1'b0;
      mid_press = held_ticks >= timing.medium_press_ticks &&
                  held_ticks < timing.long_press_ticks;
      long_press = held_ticks >= timing.long_press_ticks;
      if (mid_press && !is_off) begin
        if (!blink_on) begin
          enter_blink();
        end else begin
          blink_tick = 1'b0;
          blink_on = 1'b0;
          void'(light_start(resume_light));
        end
      end else if (long_press) begin
        if (!is_off) begin
          blink_tick = 1'b0;
          is_off = 1'b1;
          lit = '0;
        end else if (!blink_on) begin
          is_off = 1'b0;
          void'(light_start(press_light));
        end else begin
          is_off = 1'b0;
          enter_blink();
        end
      end else if (resume_light == LIGHT_GREEN &&
                   held_ticks < timing.medium_press_ticks && !blink_on) begin
        void'(light_start(LIGHT_YELLOW));
      end else begin
        void'(light_start(press_light));
      end
    end
    btn_q = level;
    res.green_lamp  = lit[LAMP_G];
    res.yellow_lamp = lit[LAMP_Y];
    res.red_lamp    = lit[LAMP_R];
    res.press_lamp  = blue_q;
    res.mode        = is_off ? MODE_OFF : (blink_on ? MODE_BLINK : MODE_NORMAL);
    return res;
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      0:       return $urandom_range(0, 99) < 32;
      1:       return $urandom_range(0, 99) < 51;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_idles();
    case (idle_mode)
      0:       return $urandom_range(0, 99) < 51;
      1:       return $urandom_range(0, 99) < 32;
      default: return 1'b0;
    endcase
  endfunction

  // Request driver: a new request is offered only once the previous one
  // has been taken, so a stalled request never changes.
  always @(negedge clk) begin
    if (!in_valid || offer_taken) begin
      if (tick_queue.size() != 0 && !sender_idles()) begin
        in_valid <= 1'b1;
        in_button_level <= tick_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side stall, with an occasional long hold-off that fills the block.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_idles();
    end
  end

  // Prediction and checking share one process so that a prediction is always
  // queued before the result it belongs to is compared.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    offer_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      lamp_expect.push_back(advance_tick(in_button_level));
      ticks_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      got.green_lamp  = out_green_lamp;
      got.yellow_lamp = out_yellow_lamp;
      got.red_lamp    = out_red_lamp;
      got.press_lamp  = out_press_lamp;
      got.mode        = out_mode;
      if (lamp_expect.size() == 0) begin
        if (mismatches < 10)
          $display("tb: unexpected result at %0t: g%0b y%0b r%0b p%0b mode %0d", $realtime,
                   got.green_lamp, got.yellow_lamp, got.red_lamp, got.press_lamp, got.mode);
        mismatches++;
      end else begin
        want = lamp_expect.pop_front();
        if (got.green_lamp !== want.green_lamp || got.yellow_lamp !== want.yellow_lamp ||
            got.red_lamp !== want.red_lamp || got.press_lamp !== want.press_lamp ||
            got.mode !== want.mode) begin
          if (mismatches < 10)
            $display("tb: mismatch at %0t: expected g%0b y%0b r%0b p%0b mode %0d, %s",
                     $realtime, want.green_lamp, want.yellow_lamp, want.red_lamp,
                     want.press_lamp, want.mode,
                     $sformatf("got g%0b y%0b r%0b p%0b mode %0d", got.green_lamp,
                               got.yellow_lamp, got.red_lamp, got.press_lamp, got.mode));
          mismatches++;
        end
      end
    end
  end

  task automatic queue_tick(logic level);
    tick_queue.push_back(level);
    ticks_queued++;
  endtask

  task automatic queue_press(int unsigned len, int unsigned gap);
    repeat (len) queue_tick(1'b1);
    repeat (gap) queue_tick(1'b0);
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (ticks_taken != ticks_queued || lamp_expect.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [TickW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (cfg_ready !== 1'b1);
    case (idx)
      CFG_GREEN:  timing.green_ticks = val;
      CFG_YELLOW: timing.yellow_ticks = val;
      CFG_RED:    timing.red_ticks = val;
      CFG_MEDIUM: timing.medium_press_ticks = val;
      CFG_LONG:   timing.long_press_ticks = val;
      default: ;
    endcase
  endtask

  task automatic start_phase(int mode, logic [TickW-1:0] g, logic [TickW-1:0] y,
                             logic [TickW-1:0] r, logic [TickW-1:0] m,
                             logic [TickW-1:0] l);
    wait_drain();
    idle_mode = mode;
    write_reg(CFG_GREEN, g);
    write_reg(CFG_YELLOW, y);
    write_reg(CFG_RED, r);
    write_reg(CFG_MEDIUM, m);
    write_reg(CFG_LONG, l);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed presses sized against the current thresholds, with
  // some random button noise in between.
  task automatic fill_random(int n);
    int          start;
    int unsigned m;
    int unsigned l;
    int unsigned short_max;
    int unsigned len;
    start = ticks_queued;
    m = timing.medium_press_ticks;
    l = timing.long_press_ticks;
    short_max = (m < l ? m : l) - 1;
    while (ticks_queued - start < n) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 6)) queue_tick(1'($urandom_range(0, 1)));
      end else begin
        len = 0;
        case ($urandom_range(0, 2))
          0: if (short_max >= 1) len = $urandom_range(1, short_max < 30 ? short_max : 30);
          1: if (m < l && m <= 40) len = $urandom_range(m, (l - 1 < m + 30) ? l - 1 : m + 30);
          default: if (l <= 40) len = $urandom_range(l, l + 6);
        endcase
        if (len == 0) len = $urandom_range(1, 4);
        queue_press(len, $urandom_range(1, 10));
      end
    end
  endtask

  // Directed presses for a medium threshold of 3 and a long threshold of 5:
  // short press, medium press into blinking, short press while blinking,
  // long press into shutdown with blinking kept, long press back to blinking.
  localparam logic [22:0] DirectedTicks = 23'b00_10_1110_110_111110_111110;

  initial begin
    timing = '{RST_GREEN_TICKS, RST_YELLOW_TICKS, RST_RED_TICKS,
               RST_MEDIUM_TICKS, RST_LONG_TICKS};
    lit = '0;
    lit[LAMP_G] = 1'b1;
    phase_left = RST_GREEN_TICKS;
    next_light = LIGHT_YELLOW;
    blink_on = 1'b0;
    blink_tick = 1'b0;
    is_off = 1'b0;
    resume_light = LIGHT_GREEN;
    press_light = LIGHT_GREEN;
    shown_light = LIGHT_GREEN;
    held_ticks = '0;
    btn_q = 1'b0;
    blue_q = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A short press on green under the reset timing jumps to yellow.
    queue_press(0, 1);
    queue_press(1, 2);

    start_phase(0, 16'd4, 16'd2, 16'd3, 16'd3, 16'd5);
    for (int i = 22; i >= 0; i--) queue_tick(DirectedTicks[i]);
    fill_random(150);
    hold_req = 1'b1;

    start_phase(0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2);
    fill_random(170);
    // Zero phase lengths behave as one tick.
    start_phase(0, 16'd0, 16'd2, 16'd0, 16'd2, 16'd4);
    fill_random(170);

    // Medium threshold above the long one leaves no medium band.
    start_phase(1, 16'd5, 16'd3, 16'd4, 16'd6, 16'd4);
    fill_random(170);
    hold_req = 1'b1;
    start_phase(1, 16'd3, 16'd2, 16'd2, 16'd1, 16'd1);
    fill_random(170);
    start_phase(1, 16'd6, 16'd4, 16'd5, 16'd2, 16'd8);
    fill_random(170);

    // All registers at their maximum, so every press counts as short.
    start_phase(2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_press(40, 3);
    fill_random(60);
    start_phase(2, 16'd2, 16'd3, 16'd1, 16'd4, 16'd9);
    fill_random(300);

    wait_drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
